/* hw/rtl/osmub_pkg.sv */
// Shared types, constants and score rounding for the order statistic mean bound block.
// Used by every module in hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package osmub_pkg;

	localparam int unsigned SAMPLES_DEF = 4;
	localparam int unsigned ROWS_DEF    = 1024;
	localparam int unsigned VAL_W       = 17;
	localparam int unsigned ROW_W       = 10;
	localparam int unsigned COL_W       = 2;
	localparam int unsigned RANK_W      = 10;
	localparam int unsigned FQ_DEPTH    = 4;
	localparam int unsigned FQ_AW       = 2;

	localparam logic [VAL_W-1:0]  ONE_Q16    = 17'd65536;
	localparam logic [RANK_W-1:0] RANK_RESET = 10'd51;

	typedef enum logic {
		KIND_TABLE,
		KIND_SAMPLE
	} item_kind_t;

	typedef struct packed {
		item_kind_t        kind;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  column;
		logic [VAL_W-1:0]  value;
		logic              last;
	} item_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_SCORE,
		ENG_SELECT,
		ENG_DONE
	} eng_state_t;

	typedef struct packed {
		logic start;
		logic tbl_we;
	} eng_ctl_t;

	function automatic logic [VAL_W-1:0] round_score(input logic [32:0] acc);
		logic [32:0] rem;
		logic [33:0] rnd;
		logic [17:0] q;
		begin
			rem = acc[32] ? 33'd0 : (33'h1_0000_0000 - acc);
			rnd = {1'b0, rem} + 34'd32768;
			q   = rnd[33:16];
			round_score = (q > 18'(ONE_Q16)) ? ONE_Q16 : q[VAL_W-1:0];
		end
	endfunction

endpackage

/* hw/rtl/osmub_front.sv */
// Front end: accepts requests, saturates values, drops out-of-range table writes, queues the rest.
// Depends on osmub_pkg.
`timescale 1ns / 1ps

module osmub_front #(
	parameter int unsigned SAMPLES = osmub_pkg::SAMPLES_DEF,
	parameter int unsigned ROWS    = osmub_pkg::ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic                             mode,
	input  logic [osmub_pkg::ROW_W-1:0]      row,
	input  logic [osmub_pkg::COL_W-1:0]      column,
	input  logic [osmub_pkg::VAL_W-1:0]      value,
	input  logic                             last,
	input  logic                             item_pop,
	output logic                             item_valid,
	output osmub_pkg::item_t                 item
);

	osmub_pkg::item_t                  fifo_q [osmub_pkg::FQ_DEPTH];
	logic [osmub_pkg::FQ_AW-1:0]       wr_ptr_q;
	logic [osmub_pkg::FQ_AW-1:0]       rd_ptr_q;
	logic [osmub_pkg::FQ_AW:0]         count_q;
	osmub_pkg::item_t                  in_item;
	logic                              in_ok;
	logic                              enq;
	logic                              deq;

	always_comb begin
		in_item.kind   = mode ? osmub_pkg::KIND_SAMPLE : osmub_pkg::KIND_TABLE;
		in_item.row    = row;
		in_item.column = column;
		in_item.value  = (value > osmub_pkg::ONE_Q16) ? osmub_pkg::ONE_Q16 : value;
		in_item.last   = last;
		in_ok = mode || ((32'(row) < ROWS) && (32'(column) < SAMPLES));
	end

	assign full       = (count_q == (osmub_pkg::FQ_AW + 1)'(osmub_pkg::FQ_DEPTH));
	assign item_valid = (count_q != '0);
	assign item       = fifo_q[rd_ptr_q];
	assign enq        = push && !full && in_ok;
	assign deq        = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (enq) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (deq && !enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/osmub_engine.sv */
// Score engine: reference table memory, per-row scoring pipeline, score memory, radix select.
// Depends on osmub_pkg.
`timescale 1ns / 1ps

module osmub_engine #(
	parameter int unsigned SAMPLES = osmub_pkg::SAMPLES_DEF,
	parameter int unsigned ROWS    = osmub_pkg::ROWS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  osmub_pkg::eng_ctl_t                    ctl,
	input  logic [osmub_pkg::ROW_W-1:0]            tbl_row,
	input  logic [osmub_pkg::COL_W-1:0]            tbl_col,
	input  logic [osmub_pkg::VAL_W-1:0]            tbl_value,
	input  logic [SAMPLES-1:0][osmub_pkg::VAL_W-1:0] samples,
	input  logic [osmub_pkg::RANK_W-1:0]           rank,
	output logic                                   done,
	output logic [osmub_pkg::VAL_W-1:0]            result
);

	localparam int unsigned TD = ROWS * SAMPLES;
	localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned CW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int unsigned TW = (TD > 1) ? $clog2(TD) : 1;
	localparam int unsigned KW = $clog2(ROWS + 1);
	localparam int unsigned VW = osmub_pkg::VAL_W;

	osmub_pkg::eng_state_t state_q, state_d;

	logic [VW-1:0]  tbl_mem   [TD];
	logic [VW-1:0]  score_mem [ROWS];

	logic [VW-1:0]  gaps [SAMPLES];
	logic [TW-1:0]  tbl_wa;

	logic [TW-1:0]  rd_addr_q;
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic           iss_end_q;
	logic           issue;

	logic           v_s1, first_s1, lastc_s1, fin_s1;
	logic [RW-1:0]  row_s1;
	logic [VW-1:0]  tbl_rdata_s1, gap_s1;
	logic           v_s2, first_s2, lastc_s2, fin_s2;
	logic [RW-1:0]  row_s2;
	logic [33:0]    prod_s2;
	logic           wv_s3, fin_s3;
	logic [RW-1:0]  row_s3;
	logic [32:0]    acc_s3;

	logic [4:0]     bit_q;
	logic [VW-1:0]  prefix_q;
	logic [RW-1:0]  sel_addr_q;
	logic           sel_end_q;
	logic           rv_s1, rlast_s1;
	logic [VW-1:0]  score_rdata_s1;
	logic [KW-1:0]  cnt_q;
	logic [VW-1:0]  cand;
	logic [KW-1:0]  cnt_new;
	logic [31:0]    rank_eff;
	logic           sel_issue;
	logic           score_fin;
	logic           sel_fin;

	always_comb begin
		for (int i = 0; i < SAMPLES; i++) begin
			if (i < SAMPLES - 1) begin
				gaps[i] = samples[(i + 1) % SAMPLES] - samples[i];
			end else begin
				gaps[i] = osmub_pkg::ONE_Q16 - samples[i];
			end
		end
	end

	assign tbl_wa    = TW'(32'(tbl_row) * SAMPLES + 32'(tbl_col));
	assign issue     = (state_q == osmub_pkg::ENG_SCORE) && !iss_end_q;
	assign sel_issue = (state_q == osmub_pkg::ENG_SELECT) && !sel_end_q;
	assign rank_eff  = (32'(rank) >= ROWS) ? (ROWS - 1) : 32'(rank);
	assign cand      = prefix_q | (VW'(1) << bit_q);
	assign cnt_new   = cnt_q + KW'(score_rdata_s1 >= cand);
	assign score_fin = wv_s3 && fin_s3;
	assign sel_fin   = rv_s1 && rlast_s1 && (bit_q == 5'd0);

	always_ff @(posedge clk) begin
		if (ctl.tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_value;
		end
		tbl_rdata_s1 <= tbl_mem[rd_addr_q];
	end

	always_ff @(posedge clk) begin
		if (wv_s3) begin
			score_mem[row_s3] <= osmub_pkg::round_score(acc_s3);
		end
		score_rdata_s1 <= score_mem[sel_addr_q];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			osmub_pkg::ENG_IDLE:   if (ctl.start) state_d = osmub_pkg::ENG_SCORE;
			osmub_pkg::ENG_SCORE:  if (score_fin) state_d = osmub_pkg::ENG_SELECT;
			osmub_pkg::ENG_SELECT: if (sel_fin)   state_d = osmub_pkg::ENG_DONE;
			osmub_pkg::ENG_DONE:   state_d = osmub_pkg::ENG_IDLE;
			default:               state_d = osmub_pkg::ENG_IDLE;
		endcase
	end

	always_comb begin
		done   = (state_q == osmub_pkg::ENG_DONE);
		result = prefix_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osmub_pkg::ENG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scoring pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
			iss_end_q <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			wv_s3     <= 1'b0;
		end else begin
			if (ctl.start) begin
				rd_addr_q <= '0;
				col_q     <= '0;
				row_q     <= '0;
				iss_end_q <= 1'b0;
			end else if (issue) begin
				rd_addr_q <= rd_addr_q + 1'b1;
				if (32'(rd_addr_q) == TD - 1) begin
					iss_end_q <= 1'b1;
				end
				if (32'(col_q) == SAMPLES - 1) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			v_s1  <= issue;
			v_s2  <= v_s1;
			wv_s3 <= v_s2 && lastc_s2;
		end
	end

	always_ff @(posedge clk) begin
		gap_s1   <= gaps[col_q];
		first_s1 <= (col_q == '0);
		lastc_s1 <= (32'(col_q) == SAMPLES - 1);
		fin_s1   <= (32'(rd_addr_q) == TD - 1);
		row_s1   <= row_q;
		prod_s2  <= 34'(tbl_rdata_s1) * 34'(gap_s1);
		first_s2 <= first_s1;
		lastc_s2 <= lastc_s1;
		fin_s2   <= fin_s1;
		row_s2   <= row_s1;
		if (v_s2) begin
			acc_s3 <= first_s2 ? prod_s2[32:0] : (acc_s3 + prod_s2[32:0]);
		end
		fin_s3 <= fin_s2;
		row_s3 <= row_s2;
	end

	// radix select, one bit per sweep over the scores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q      <= '0;
			prefix_q   <= '0;
			sel_addr_q <= '0;
			sel_end_q  <= 1'b1;
			cnt_q      <= '0;
			rv_s1      <= 1'b0;
			rlast_s1   <= 1'b0;
		end else begin
			rv_s1    <= sel_issue;
			rlast_s1 <= sel_issue && (32'(sel_addr_q) == ROWS - 1);
			if (score_fin) begin
				bit_q      <= 5'(VW - 1);
				prefix_q   <= '0;
				sel_addr_q <= '0;
				sel_end_q  <= 1'b0;
				cnt_q      <= '0;
			end else begin
				if (sel_issue) begin
					sel_addr_q <= sel_addr_q + 1'b1;
					if (32'(sel_addr_q) == ROWS - 1) begin
						sel_end_q <= 1'b1;
					end
				end
				if (rv_s1) begin
					if (rlast_s1) begin
						cnt_q <= '0;
						if (32'(cnt_new) > rank_eff) begin
							prefix_q <= cand;
						end
						if (bit_q != 5'd0) begin
							bit_q      <= bit_q - 1'b1;
							sel_addr_q <= '0;
							sel_end_q  <= 1'b0;
						end
					end else begin
						cnt_q <= cnt_new;
					end
				end
			end
		end
	end

endmodule

/* hw/rtl/osmub_back.sv */
// Back end: executes queued requests, keeps the sorted sample set, holds the result register.
// Depends on osmub_pkg; drives osmub_engine through an osmub_pkg::eng_ctl_t.
`timescale 1ns / 1ps

module osmub_back #(
	parameter int unsigned SAMPLES = osmub_pkg::SAMPLES_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     item_valid,
	input  osmub_pkg::item_t                         item,
	output logic                                     item_pop,
	input  logic                                     cfg_we,
	input  logic [osmub_pkg::RANK_W-1:0]             cfg_wdata,
	output osmub_pkg::eng_ctl_t                      ctl,
	input  logic                                     eng_done,
	input  logic [osmub_pkg::VAL_W-1:0]              eng_result,
	output logic [SAMPLES-1:0][osmub_pkg::VAL_W-1:0] samples,
	output logic [osmub_pkg::RANK_W-1:0]             rank,
	output logic                                     res_valid,
	output logic [osmub_pkg::VAL_W-1:0]              res_bound,
	output logic                                     res_err,
	input  logic                                     res_pop
);

	localparam int unsigned NW = $clog2(SAMPLES + 2);
	localparam int unsigned VW = osmub_pkg::VAL_W;

	logic [SAMPLES-1:0][VW-1:0] samples_q;
	logic [SAMPLES-1:0][VW-1:0] ins;
	logic [SAMPLES-1:0]         le;
	logic [NW-1:0]              cnt_q;
	logic [NW-1:0]              cnt_new;
	logic [osmub_pkg::RANK_W-1:0] rank_q;
	logic                       busy_q;
	logic                       res_valid_q;
	logic [VW-1:0]              res_bound_q;
	logic                       res_err_q;
	logic                       is_sample;
	logic                       fire_last;
	logic                       set_ok;

	always_comb begin
		for (int i = 0; i < SAMPLES; i++) begin
			le[i] = (32'(i) < 32'(cnt_q)) && (samples_q[i] <= item.value);
		end
		for (int i = 0; i < SAMPLES; i++) begin
			if (le[i]) begin
				ins[i] = samples_q[i];
			end else if (i == 0) begin
				ins[i] = item.value;
			end else if (le[(i + SAMPLES - 1) % SAMPLES]) begin
				ins[i] = item.value;
			end else begin
				ins[i] = samples_q[(i + SAMPLES - 1) % SAMPLES];
			end
		end
	end

	assign is_sample = (item.kind == osmub_pkg::KIND_SAMPLE);
	assign item_pop  = item_valid && !busy_q && !(is_sample && item.last && res_valid_q);
	assign fire_last = item_pop && is_sample && item.last;
	assign cnt_new   = (32'(cnt_q) >= SAMPLES) ? NW'(SAMPLES + 1) : (cnt_q + 1'b1);
	assign set_ok    = (32'(cnt_new) == SAMPLES);

	always_comb begin
		ctl.start  = fire_last && set_ok;
		ctl.tbl_we = item_pop && !is_sample;
	end

	assign samples   = samples_q;
	assign rank      = rank_q;
	assign res_valid = res_valid_q;
	assign res_bound = res_bound_q;
	assign res_err   = res_err_q;

	always_ff @(posedge clk) begin
		if (item_pop && is_sample && (32'(cnt_q) < SAMPLES)) begin
			samples_q <= ins;
		end
		if (fire_last && !set_ok) begin
			res_bound_q <= '0;
			res_err_q   <= 1'b1;
		end else if (eng_done) begin
			res_bound_q <= eng_result;
			res_err_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rank_q      <= osmub_pkg::RANK_RESET;
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rank_q <= cfg_wdata;
			end
			if (fire_last) begin
				cnt_q <= '0;
			end else if (item_pop && is_sample) begin
				cnt_q <= cnt_new;
			end
			if (ctl.start) begin
				busy_q <= 1'b1;
			end else if (eng_done) begin
				busy_q <= 1'b0;
			end
			if ((fire_last && !set_ok) || eng_done) begin
				res_valid_q <= 1'b1;
			end else if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/order_statistic_mean_upper_bound.sv */
// Top level of the order statistic mean upper bound; depends on osmub_pkg, osmub_front,
// osmub_back and osmub_engine.
// Table and sample requests go through a 4-entry queue, one per cycle unless it is full or
// the back end stalls. Last sample: scoring (one table read per cycle), then bitwise
// selection and loading of the result; requests stall meanwhile.
// Reset clears control, count and rank (51); table and score memories hold no reset value.
`timescale 1ns / 1ps

module order_statistic_mean_upper_bound #(
	parameter int unsigned SAMPLES = osmub_pkg::SAMPLES_DEF,
	parameter int unsigned ROWS    = osmub_pkg::ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              mode,
	input  logic [osmub_pkg::ROW_W-1:0]       row,
	input  logic [osmub_pkg::COL_W-1:0]       column,
	input  logic [osmub_pkg::VAL_W-1:0]       value,
	input  logic                              last,
	input  logic                              quantile_rank_we,
	input  logic [osmub_pkg::RANK_W-1:0]      quantile_rank_wdata,
	output logic                              empty,
	input  logic                              pop,
	output logic [osmub_pkg::VAL_W-1:0]       bound,
	output logic                              count_error
);

	osmub_pkg::item_t                         item;
	logic                                     item_valid;
	logic                                     item_pop;
	osmub_pkg::eng_ctl_t                      ctl;
	logic                                     eng_done;
	logic [osmub_pkg::VAL_W-1:0]              eng_result;
	logic [SAMPLES-1:0][osmub_pkg::VAL_W-1:0] samples;
	logic [osmub_pkg::RANK_W-1:0]             rank;
	logic                                     res_valid;

	osmub_front #(.SAMPLES(SAMPLES), .ROWS(ROWS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.row        (row),
		.column     (column),
		.value      (value),
		.last       (last),
		.item_pop   (item_pop),
		.item_valid (item_valid),
		.item       (item)
	);

	osmub_back #(.SAMPLES(SAMPLES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.cfg_we     (quantile_rank_we),
		.cfg_wdata  (quantile_rank_wdata),
		.ctl        (ctl),
		.eng_done   (eng_done),
		.eng_result (eng_result),
		.samples    (samples),
		.rank       (rank),
		.res_valid  (res_valid),
		.res_bound  (bound),
		.res_err    (count_error),
		.res_pop    (pop)
	);

	osmub_engine #(.SAMPLES(SAMPLES), .ROWS(ROWS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.tbl_row   (item.row),
		.tbl_col   (item.column),
		.tbl_value (item.value),
		.samples   (samples),
		.rank      (rank),
		.done      (eng_done),
		.result    (eng_result)
	);

	assign empty = !res_valid;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && count_error) |-> (bound == '0))
		else $error("error result with nonzero bound");

	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> empty)
		else $error("scoring started while a result waits");

	a_done_shows: assert property (@(posedge clk) disable iff (!arst_n)
		eng_done |=> (!empty && !count_error))
		else $error("finished score not presented");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> !item_pop)
		else $error("request executed during scoring");

endmodule

/* tb/order_statistic_mean_upper_bound_tb.sv */
// Self-checking testbench for order_statistic_mean_upper_bound: fills the reference table,
// sends sample sets and predicts each bound in SV. Depends on osmub_pkg and the RTL top.
`timescale 1ns / 1ps

module order_statistic_mean_upper_bound_tb;

	localparam int unsigned N_SMP  = osmub_pkg::SAMPLES_DEF;
	localparam int unsigned N_ROWS = osmub_pkg::ROWS_DEF;

	typedef struct {
		osmub_pkg::item_kind_t          kind;
		logic [osmub_pkg::ROW_W-1:0]    row;
		logic [osmub_pkg::COL_W-1:0]    column;
		logic [osmub_pkg::VAL_W-1:0]    value;
		logic                           last;
	} request_t;

	typedef struct {
		logic [osmub_pkg::VAL_W-1:0] bound;
		logic                        count_error;
	} bound_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic mode;
	logic [osmub_pkg::ROW_W-1:0] row;
	logic [osmub_pkg::COL_W-1:0] column;
	logic [osmub_pkg::VAL_W-1:0] value;
	logic last;
	logic quantile_rank_we;
	logic [osmub_pkg::RANK_W-1:0] quantile_rank_wdata;
	logic empty;
	logic pop;
	logic [osmub_pkg::VAL_W-1:0] bound;
	logic count_error;

	order_statistic_mean_upper_bound dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.row(row),
		.column(column),
		.value(value),
		.last(last),
		.quantile_rank_we(quantile_rank_we),
		.quantile_rank_wdata(quantile_rank_wdata),
		.empty(empty),
		.pop(pop),
		.bound(bound),
		.count_error(count_error)
	);

	// predictor state
	logic [osmub_pkg::VAL_W-1:0]  ref_table [N_ROWS*N_SMP];
	logic [osmub_pkg::VAL_W-1:0]  set_sorted [N_SMP];
	int unsigned                  set_count;
	logic [osmub_pkg::RANK_W-1:0] rank_sel;

	request_t    request_q[$];
	bound_t      bound_q[$];
	request_t    cur_req;
	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned n_requests;
	int unsigned n_bounds;
	int unsigned n_count_err;
	int unsigned n_mismatch;
	int unsigned n_valid_sets;
	int unsigned hold_cnt;
	int unsigned stall_mode;
	int unsigned stall_timer;
	bit          hold_req;
	bit          hold_taken;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [osmub_pkg::VAL_W-1:0] clamp_q16(logic [osmub_pkg::VAL_W-1:0] v);
		return (v > osmub_pkg::ONE_Q16) ? osmub_pkg::ONE_Q16 : v;
	endfunction

	function automatic logic [osmub_pkg::VAL_W-1:0] score_for_row(int unsigned r);
		logic [63:0] acc;
		logic [63:0] rem;
		logic [63:0] q;
		acc = 0;
		for (int i = 0; i + 1 < N_SMP; i++)
			acc += 64'(set_sorted[i+1] - set_sorted[i]) * 64'(ref_table[r*N_SMP+i]);
		acc += 64'(osmub_pkg::ONE_Q16 - set_sorted[N_SMP-1])
			* 64'(ref_table[r*N_SMP+N_SMP-1]);
		rem = (acc >= 64'h1_0000_0000) ? 64'd0 : 64'h1_0000_0000 - acc;
		q = (rem + 64'd32768) >> 16;
		return (q > 64'(osmub_pkg::ONE_Q16)) ? osmub_pkg::ONE_Q16 : q[osmub_pkg::VAL_W-1:0];
	endfunction

	function automatic logic [osmub_pkg::VAL_W-1:0] select_bound();
		int unsigned scores[$];
		int unsigned k;
		for (int unsigned r = 0; r < N_ROWS; r++)
			scores.push_back(32'(score_for_row(r)));
		scores.rsort();
		k = (32'(rank_sel) >= N_ROWS) ? N_ROWS - 1 : 32'(rank_sel);
		return osmub_pkg::VAL_W'(scores[k]);
	endfunction

	task automatic apply_request(request_t rq);
		logic [osmub_pkg::VAL_W-1:0] v;
		int i;
		bound_t res;
		v = clamp_q16(rq.value);
		if (rq.kind == osmub_pkg::KIND_TABLE) begin
			if (rq.row < N_ROWS && rq.column < N_SMP)
				ref_table[rq.row*N_SMP+rq.column] = v;
			return;
		end
		if (set_count >= N_SMP) begin
			set_count = N_SMP + 1;
		end else begin
			i = int'(set_count);
			while (i > 0 && set_sorted[i-1] > v) begin
				set_sorted[i] = set_sorted[i-1];
				i--;
			end
			set_sorted[i] = v;
			set_count++;
		end
		if (!rq.last)
			return;
		if (set_count == N_SMP) begin
			res.bound = select_bound();
			res.count_error = 1'b0;
			n_valid_sets++;
		end else begin
			res.bound = '0;
			res.count_error = 1'b1;
			n_count_err++;
		end
		bound_q.push_back(res);
		set_count = 0;
	endtask

	// driver: bursts and gaps, push held across back-to-back requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				apply_request(cur_req);
				n_requests++;
			end
			if (!push || !full) begin
				if (gap_left > 0) begin
					push <= 1'b0;
					gap_left--;
				end else if (request_q.size() > 0) begin
					cur_req = request_q.pop_front();
					push <= 1'b1;
					mode <= (cur_req.kind == osmub_pkg::KIND_SAMPLE);
					row <= cur_req.row;
					column <= cur_req.column;
					value <= cur_req.value;
					last <= cur_req.last;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
						gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 5);
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: check results, stall on its own pattern
	always @(posedge clk) begin
		bound_t exp_res;
		if (arst_n) begin
			if (pop && !empty) begin
				n_bounds++;
				if (bound_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("unexpected result: bound=%0d count_error=%0b",
							bound, count_error);
				end else begin
					exp_res = bound_q.pop_front();
					if (bound !== exp_res.bound || count_error !== exp_res.count_error) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("mismatch: bound exp %0d got %0d, count_error exp %0b got %0b",
								exp_res.bound, bound, exp_res.count_error, count_error);
					end
				end
			end
			if (stall_timer == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_timer = $urandom_range(50, 400);
			end else begin
				stall_timer--;
			end
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_cnt = 500;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				pop <= 1'b0;
			end else if (stall_mode == 0) begin
				pop <= 1'b1;
			end else if (stall_mode == 1) begin
				pop <= ($urandom_range(0, 9) < 6);
			end else begin
				pop <= (stall_timer % 5) >= 2;
			end
		end
	end

	task automatic add_req(osmub_pkg::item_kind_t k, int unsigned r, int unsigned c,
		int unsigned v, bit l);
		request_t rq;
		rq.kind = k;
		rq.row = osmub_pkg::ROW_W'(r);
		rq.column = osmub_pkg::COL_W'(c);
		rq.value = osmub_pkg::VAL_W'(v);
		rq.last = l;
		request_q.push_back(rq);
	endtask

	task automatic add_row(int unsigned r);
		int unsigned v[N_SMP];
		foreach (v[i])
			v[i] = $urandom_range(0, 65536);
		v.sort();
		if ($urandom_range(0, 15) == 0)
			v[N_SMP-1] = $urandom_range(65537, 131071);
		foreach (v[i])
			add_req(osmub_pkg::KIND_TABLE, r, i, v[i], bit'($urandom_range(0, 1)));
	endtask

	function automatic int unsigned rand_sample();
		return $urandom_range(0, 19) == 0 ? $urandom_range(65537, 131071)
			: $urandom_range(0, 65536);
	endfunction

	task automatic add_set(int unsigned n, bit mid_write);
		for (int unsigned i = 0; i < n; i++) begin
			if (mid_write && i == 1)
				add_req(osmub_pkg::KIND_TABLE, $urandom_range(0, N_ROWS-1),
					$urandom_range(0, N_SMP-1), $urandom_range(0, 65536), 1'b1);
			add_req(osmub_pkg::KIND_SAMPLE, $urandom_range(0, N_ROWS-1), $urandom_range(0, 3),
				rand_sample(), i == n - 1);
		end
	endtask

	task automatic drain();
		while (request_q.size() > 0 || push || bound_q.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_rank(int unsigned v);
		quantile_rank_we <= 1'b1;
		quantile_rank_wdata <= osmub_pkg::RANK_W'(v);
		@(posedge clk);
		quantile_rank_we <= 1'b0;
		rank_sel = osmub_pkg::RANK_W'(v);
		@(posedge clk);
	endtask

	task automatic random_phase(int unsigned n_items, int unsigned n_valid);
		int unsigned start_cnt;
		int unsigned valid_done;
		int unsigned pick;
		start_cnt = request_q.size() + n_requests;
		valid_done = 0;
		while (request_q.size() + n_requests - start_cnt < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				add_row($urandom_range(0, N_ROWS-1));
			end else if (pick < 75) begin
				add_set($urandom_range(0, 1) ? $urandom_range(1, N_SMP-1)
					: $urandom_range(N_SMP+1, N_SMP+3), bit'($urandom_range(0, 1)));
			end else if (pick < 90 && valid_done < n_valid) begin
				add_set(N_SMP, bit'($urandom_range(0, 1)));
				valid_done++;
			end else begin
				add_req(osmub_pkg::KIND_SAMPLE, $urandom_range(0, N_ROWS-1),
					$urandom_range(0, 3), rand_sample(), 1'b0);
			end
		end
		while (valid_done < n_valid) begin
			add_set(N_SMP, 1'b0);
			valid_done++;
		end
		drain();
	endtask

	initial begin
		push = 1'b0;
		pop = 1'b0;
		mode = 1'b0;
		row = '0;
		column = '0;
		value = '0;
		last = 1'b0;
		quantile_rank_we = 1'b0;
		quantile_rank_wdata = '0;
		set_count = 0;
		rank_sel = osmub_pkg::RANK_RESET;
		burst_left = 0;
		gap_left = 0;
		n_requests = 0;
		n_bounds = 0;
		n_count_err = 0;
		n_mismatch = 0;
		n_valid_sets = 0;
		hold_cnt = 0;
		hold_req = 1'b0;
		hold_taken = 1'b0;
		stall_mode = 0;
		stall_timer = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// fill the whole table, extremes in the first and last rows
		for (int unsigned c = 0; c < N_SMP; c++)
			add_req(osmub_pkg::KIND_TABLE, 0, c, c == N_SMP - 1 ? 65536 : 0, 1'b0);
		for (int unsigned r = 1; r < N_ROWS - 1; r++)
			add_row(r);
		for (int unsigned c = 0; c < N_SMP; c++)
			add_req(osmub_pkg::KIND_TABLE, N_ROWS - 1, c, 131071, 1'b1);

		// directed sets at reset rank
		add_req(osmub_pkg::KIND_SAMPLE, 0, 0, 65536, 1'b0);
		add_req(osmub_pkg::KIND_SAMPLE, 1023, 3, 0, 1'b0);
		add_req(osmub_pkg::KIND_TABLE, 5, 2, 40000, 1'b1);
		add_req(osmub_pkg::KIND_SAMPLE, 0, 0, 131071, 1'b0);
		add_req(osmub_pkg::KIND_SAMPLE, 0, 0, 32768, 1'b1);
		add_req(osmub_pkg::KIND_SAMPLE, 0, 0, 100, 1'b1);
		for (int i = 0; i < 6; i++)
			add_req(osmub_pkg::KIND_SAMPLE, 0, 0, 1000 * i, i == 5);
		for (int i = 0; i < N_SMP; i++)
			add_req(osmub_pkg::KIND_SAMPLE, 0, 0, 0, i == N_SMP - 1);
		for (int i = 0; i < N_SMP; i++)
			add_req(osmub_pkg::KIND_SAMPLE, 0, 0, 65536, i == N_SMP - 1);
		drain();

		// long receiver hold-off while short sets pile up
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			add_req(osmub_pkg::KIND_SAMPLE, 0, 0, rand_sample(), 1'b1);
		drain();

		random_phase(350, 6);
		write_rank(0);
		add_set(N_SMP, 1'b0);
		random_phase(350, 5);
		write_rank(1023);
		random_phase(350, 5);
		write_rank($urandom_range(1, 1022));
		random_phase(350, 5);
		write_rank(51);
		repeat (50) @(posedge clk);

		$display("%0d requests accepted, %0d results checked: %0d bounds, %0d count errors",
			n_requests, n_bounds, n_valid_sets, n_count_err);
		if (n_mismatch == 0 && bound_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d results missing", n_mismatch, bound_q.size());
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#400ms;
		$display("timeout: %0d results still missing", bound_q.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
